[design/sbpr_pkg.sv]
package sbpr_pkg;

   localparam int DEF_MAX_RING_LOG = 6;
   localparam int MIN_RING_LOG     = 3;

   localparam int ADDR_W    = 64;
   localparam int ACTION_W  = 3;
   localparam int STATUS_W  = 3;
   localparam int MOVED_W   = 7;
   localparam int CFG_W     = 3;
   localparam int CSR_IDX_W = 1;

   localparam int REQ_DATA_W = ((ADDR_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((ADDR_W + MOVED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - ADDR_W - MOVED_W;

   localparam logic [CFG_W-1:0] RING_LOG_RESET = 3'd6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RING_LOG  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASTER_EN = 1'b1;

   // actions
   localparam logic [ACTION_W-1:0] ACT_ACQUIRE = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_PARTNER = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_REFILL  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_DRAIN   = 3'd4;

   // result status
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_MASTER = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DRAIN_ONE  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DRAINED    = 3'd5;

   typedef struct packed {
      logic                capture;
      logic                push_alloc_in;
      logic                push_ret_in;
      logic                read_alloc;
      logic                read_ret;
      logic                push_alloc_rd;
      logic                moved_inc;
      logic                set_status;
      logic [STATUS_W-1:0] status;
      logic                take_rd;
      logic                out_load;
   } cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                master;
      logic                alloc_empty;
      logic                alloc_full;
      logic                ret_empty;
      logic                ret_full;
      logic                out_free;
   } flags_type;

endpackage

[design/sbpr_ctrl.sv]
module sbpr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  sbpr_pkg::flags_type flags,
   output sbpr_pkg::cmd_type   cmd
);
   import sbpr_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_REFILL = 3'd3;
   localparam logic [2:0] S_MOVE   = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_DONE;
            case (flags.action)
               ACT_ACQUIRE: begin
                  if (!flags.master) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_NOT_MASTER;
                  end else if (flags.alloc_empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                  end else begin
                     cmd.read_alloc = 1'b1;
                     state_in       = S_READ;
                  end
               end
               ACT_RELEASE: begin
                  if (flags.alloc_full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                  end else begin
                     cmd.push_alloc_in = 1'b1;
                  end
               end
               ACT_PARTNER: begin
                  if (flags.ret_full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                  end else begin
                     cmd.push_ret_in = 1'b1;
                  end
               end
               ACT_REFILL: begin
                  state_in = S_REFILL;
               end
               ACT_DRAIN: begin
                  cmd.set_status = 1'b1;
                  if (!flags.ret_empty) begin
                     cmd.status   = ST_DRAIN_ONE;
                     cmd.read_ret = 1'b1;
                     state_in     = S_READ;
                  end else if (!flags.alloc_empty) begin
                     cmd.status     = ST_DRAIN_ONE;
                     cmd.read_alloc = 1'b1;
                     state_in       = S_READ;
                  end else begin
                     cmd.status = ST_DRAINED;
                  end
               end
               default: begin
               end
            endcase
         end
         S_READ: begin
            cmd.take_rd = 1'b1;
            state_in    = S_DONE;
         end
         S_REFILL: begin
            if (flags.ret_empty || flags.alloc_full) begin
               state_in = S_DONE;
            end else begin
               cmd.read_ret = 1'b1;
               state_in     = S_MOVE;
            end
         end
         S_MOVE: begin
            cmd.push_alloc_rd = 1'b1;
            cmd.moved_inc     = 1'b1;
            state_in          = S_REFILL;
         end
         S_DONE: begin
            if (flags.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/sbpr_dpath.sv]
module sbpr_dpath #(
   parameter int MAX_RING_LOG = sbpr_pkg::DEF_MAX_RING_LOG
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [sbpr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sbpr_pkg::CFG_W-1:0]          csr_wdata,
   input  logic [sbpr_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [sbpr_pkg::ACTION_W-1:0]       req_tuser,
   input  sbpr_pkg::cmd_type                   cmd,
   output sbpr_pkg::flags_type                 flags,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sbpr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [sbpr_pkg::STATUS_W-1:0]       rsp_tuser
);
   import sbpr_pkg::*;

   localparam int DEPTH = 1 << MAX_RING_LOG;
   localparam int IDX_W = MAX_RING_LOG;
   localparam int CNT_W = MAX_RING_LOG + 1;
   localparam int LG_W  = $clog2(MAX_RING_LOG + 1);

   logic [ADDR_W-1:0] alloc_mem [DEPTH];
   logic [ADDR_W-1:0] ret_mem   [DEPTH];

   logic [CFG_W-1:0]    ring_log_ff;
   logic                master_ff;
   logic [CNT_W-1:0]    alloc_enq_ff, alloc_deq_ff, ret_enq_ff, ret_deq_ff;
   logic [ACTION_W-1:0] action_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [ADDR_W-1:0]   alloc_rdata_ff, ret_rdata_ff;
   logic                rd_sel_ff;
   logic [ADDR_W-1:0]   res_buf_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic [MOVED_W-1:0]  moved_ff;
   logic                rsp_valid_ff;
   logic [ADDR_W-1:0]   rsp_buf_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [MOVED_W-1:0]  rsp_moved_ff;

   logic [LG_W-1:0]   lg_eff;
   logic [CNT_W-1:0]  ring_entries;
   logic [IDX_W-1:0]  idx_mask;
   logic [CNT_W-1:0]  alloc_occ, ret_occ;
   logic [IDX_W-1:0]  alloc_wr_idx, alloc_rd_idx, ret_wr_idx, ret_rd_idx;
   logic [ADDR_W-1:0] alloc_wdata;

   // clamp ring size to the supported range
   always_comb begin
      if (int'(ring_log_ff) < MIN_RING_LOG) begin
         lg_eff = LG_W'(MIN_RING_LOG);
      end else if (int'(ring_log_ff) > MAX_RING_LOG) begin
         lg_eff = LG_W'(MAX_RING_LOG);
      end else begin
         lg_eff = LG_W'(ring_log_ff);
      end
   end

   assign ring_entries = CNT_W'(1) << lg_eff;
   assign idx_mask     = IDX_W'(ring_entries - CNT_W'(1));
   assign alloc_occ    = alloc_enq_ff - alloc_deq_ff;
   assign ret_occ      = ret_enq_ff - ret_deq_ff;

   assign alloc_wr_idx = alloc_enq_ff[IDX_W-1:0] & idx_mask;
   assign alloc_rd_idx = alloc_deq_ff[IDX_W-1:0] & idx_mask;
   assign ret_wr_idx   = ret_enq_ff[IDX_W-1:0] & idx_mask;
   assign ret_rd_idx   = ret_deq_ff[IDX_W-1:0] & idx_mask;
   assign alloc_wdata  = cmd.push_alloc_rd ? ret_rdata_ff : addr_ff;

   assign flags.action      = action_ff;
   assign flags.master      = master_ff;
   assign flags.alloc_empty = (alloc_occ == '0);
   assign flags.alloc_full  = (alloc_occ >= ring_entries);
   assign flags.ret_empty   = (ret_occ == '0);
   assign flags.ret_full    = (ret_occ >= ring_entries);
   assign flags.out_free    = !rsp_valid_ff || rsp_tready;

   // ring memories
   always_ff @(posedge clock) begin
      if (cmd.push_alloc_in || cmd.push_alloc_rd) begin
         alloc_mem[alloc_wr_idx] <= alloc_wdata;
      end
      if (cmd.read_alloc) begin
         alloc_rdata_ff <= alloc_mem[alloc_rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_ret_in) begin
         ret_mem[ret_wr_idx] <= addr_ff;
      end
      if (cmd.read_ret) begin
         ret_rdata_ff <= ret_mem[ret_rd_idx];
      end
   end

   // control state: config and ring counters
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_log_ff  <= RING_LOG_RESET;
         master_ff    <= 1'b0;
         alloc_enq_ff <= '0;
         alloc_deq_ff <= '0;
         ret_enq_ff   <= '0;
         ret_deq_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RING_LOG:  ring_log_ff <= csr_wdata;
               CSR_MASTER_EN: master_ff   <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (cmd.push_alloc_in || cmd.push_alloc_rd) begin
            alloc_enq_ff <= alloc_enq_ff + CNT_W'(1);
         end
         if (cmd.read_alloc) begin
            alloc_deq_ff <= alloc_deq_ff + CNT_W'(1);
         end
         if (cmd.push_ret_in) begin
            ret_enq_ff <= ret_enq_ff + CNT_W'(1);
         end
         if (cmd.read_ret) begin
            ret_deq_ff <= ret_deq_ff + CNT_W'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff     <= req_tuser;
         addr_ff       <= req_tdata[ADDR_W-1:0];
         res_buf_ff    <= '0;
         res_status_ff <= ST_OK;
         moved_ff      <= '0;
      end else begin
         if (cmd.set_status) begin
            res_status_ff <= cmd.status;
         end
         if (cmd.take_rd) begin
            res_buf_ff <= rd_sel_ff ? ret_rdata_ff : alloc_rdata_ff;
         end
         if (cmd.moved_inc) begin
            moved_ff <= moved_ff + MOVED_W'(1);
         end
      end
      if (cmd.read_ret) begin
         rd_sel_ff <= 1'b1;
      end else if (cmd.read_alloc) begin
         rd_sel_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_buf_ff    <= res_buf_ff;
         rsp_status_ff <= res_status_ff;
         rsp_moved_ff  <= moved_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_moved_ff, rsp_buf_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

[design/shared_buffer_pool_rings_top.sv]
// response: result registered after the request transfer, via the read state when a ring slot is read
// one item at a time: no new request is taken until the response register is loaded
// refill: moves entries one at a time, one read and one write per entry
// reset: synchronous, active high; counters cleared, ring_log 6, master off
// ring memories are not cleared; the user must see that slots are only read after being written (not enforced)
module shared_buffer_pool_rings_top #(
   parameter int MAX_RING_LOG = sbpr_pkg::DEF_MAX_RING_LOG
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration writes
   input  logic                                csr_we,
   input  logic [sbpr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sbpr_pkg::CFG_W-1:0]          csr_wdata,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sbpr_pkg::REQ_DATA_W-1:0]     req_tdata,  // buffer_addr
   input  logic [sbpr_pkg::ACTION_W-1:0]       req_tuser,  // action
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sbpr_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // out_buffer, moved_count, zero pad
   output logic [sbpr_pkg::STATUS_W-1:0]       rsp_tuser   // status
);
   import sbpr_pkg::*;

   // command and status between sequencer and datapath
   cmd_type   cmd;
   flags_type flags;

   // sequencer: one item at a time, refill loops one entry at a time, a read state then a write state per entry
   sbpr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .flags      (flags),
      .cmd        (cmd)
   );

   // datapath: config, ring counters, two ring memories, response register
   sbpr_dpath #(
      .MAX_RING_LOG (MAX_RING_LOG)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .flags      (flags),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // a request transfer makes the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // never pop an empty ring
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.read_alloc |-> !flags.alloc_empty) and (cmd.read_ret |-> !flags.ret_empty))
      else $error("pop from empty ring");

   // never push a full ring
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      ((cmd.push_alloc_in || cmd.push_alloc_rd) |-> !flags.alloc_full)
      and (cmd.push_ret_in |-> !flags.ret_full))
      else $error("push into full ring");

   // response register only loaded when free or being drained
   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("response overwritten");

endmodule

[bench/shared_buffer_pool_rings_checker.sv]
module shared_buffer_pool_rings_checker
   import sbpr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // buffer_addr
   input  logic [ACTION_W-1:0]   req_tuser,   // action
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // out_buffer, moved_count, zero pad
   input  logic [STATUS_W-1:0]   rsp_tuser,   // status
   output int                    fail_count,
   output int                    answers_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LOG    = DEF_MAX_RING_LOG;
   localparam int RING_DEPTH = 1 << MAX_LOG;
   localparam int RING_ALLOC = 0;
   localparam int RING_RET   = 1;

   typedef logic [MAX_LOG:0] count_t;

   typedef struct packed {
      logic [ADDR_W-1:0]   buffer;
      logic [STATUS_W-1:0] status;
      logic [MOVED_W-1:0]  moved;
   } pool_answer_t;

   logic [ADDR_W-1:0] slots [2][RING_DEPTH];
   count_t            enq_cnt [2];
   count_t            deq_cnt [2];
   logic [CFG_W-1:0]  ring_log_q;
   logic              master_q;
   pool_answer_t      answers_due [$];

   // ring capacity in entries, with the log clamped to the legal range
   function automatic int ring_span();
      int lg;
      lg = ring_log_q;
      if (lg < MIN_RING_LOG) lg = MIN_RING_LOG;
      if (lg > MAX_LOG) lg = MAX_LOG;
      return 1 << lg;
   endfunction

   function automatic int held(int r);
      count_t d;
      d = enq_cnt[r] - deq_cnt[r];
      return int'(d);
   endfunction

   function automatic logic [ADDR_W-1:0] take(int r);
      logic [ADDR_W-1:0] v;
      v = slots[r][int'(deq_cnt[r]) & (ring_span() - 1)];
      deq_cnt[r] = deq_cnt[r] + 1'b1;
      return v;
   endfunction

   function automatic void put(int r, logic [ADDR_W-1:0] v);
      slots[r][int'(enq_cnt[r]) & (ring_span() - 1)] = v;
      enq_cnt[r] = enq_cnt[r] + 1'b1;
   endfunction

   function automatic pool_answer_t run_pool_action(logic [ACTION_W-1:0] action,
                                                    logic [ADDR_W-1:0] addr);
      pool_answer_t a;
      a = '0;
      case (action)
         ACT_ACQUIRE: begin
            if (!master_q) a.status = ST_NOT_MASTER;
            else if (held(RING_ALLOC) == 0) a.status = ST_EMPTY;
            else a.buffer = take(RING_ALLOC);
         end
         ACT_RELEASE: begin
            if (held(RING_ALLOC) >= ring_span()) a.status = ST_FULL;
            else put(RING_ALLOC, addr);
         end
         ACT_PARTNER: begin
            if (held(RING_RET) >= ring_span()) a.status = ST_FULL;
            else put(RING_RET, addr);
         end
         ACT_REFILL: begin
            while (held(RING_RET) != 0 && held(RING_ALLOC) < ring_span()) begin
               put(RING_ALLOC, take(RING_RET));
               a.moved = a.moved + 1'b1;
            end
         end
         ACT_DRAIN: begin
            if (held(RING_RET) != 0) begin
               a.buffer = take(RING_RET);
               a.status = ST_DRAIN_ONE;
            end else if (held(RING_ALLOC) != 0) begin
               a.buffer = take(RING_ALLOC);
               a.status = ST_DRAIN_ONE;
            end else begin
               a.status = ST_DRAINED;
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   function automatic void compare_field(string name, logic [ADDR_W-1:0] want,
                                         logic [ADDR_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      pool_answer_t due;
      if (reset) begin
         enq_cnt    = '{default: '0};
         deq_cnt    = '{default: '0};
         ring_log_q = RING_LOG_RESET;
         master_q   = 1'b0;
         fail_count = 0;
         answers_due.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_RING_LOG) ring_log_q = csr_wdata;
            else if (csr_index == CSR_MASTER_EN) master_q = csr_wdata[0];
         end
         if (req_tvalid && req_tready)
            answers_due.push_back(run_pool_action(req_tuser, req_tdata[ADDR_W-1:0]));
         if (rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               $error("response transfer with nothing outstanding: data %0h status %0d",
                      rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               due = answers_due.pop_front();
               compare_field("out_buffer", due.buffer, rsp_tdata[ADDR_W-1:0]);
               compare_field("status", due.status, rsp_tuser);
               compare_field("moved_count", due.moved, rsp_tdata[ADDR_W +: MOVED_W]);
            end
         end
      end
      answers_owed = answers_due.size();
   end

endmodule

[bench/shared_buffer_pool_rings_top_test.sv]
module shared_buffer_pool_rings_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import sbpr_pkg::*;

   localparam int ITEM_GOAL   = 1500;
   localparam int QUIET_LIMIT = 5000;   // cycles with no transfer on either side
   localparam int TAIL_CYCLES = 200;    // covers a full-depth refill after the last transfer

   // action codes the block ignores
   localparam logic [ACTION_W-1:0] ACT_FIRST_UNUSED = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_LAST_UNUSED  = 3'd7;

   // random phase styles
   localparam int FILL_UP  = 0;
   localparam int MIXED    = 1;
   localparam int RUN_DOWN = 2;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = CSR_RING_LOG;
   logic [CFG_W-1:0]      csr_wdata   = '0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [ACTION_W-1:0]   req_tuser   = ACT_ACQUIRE;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   int                    fail_count;
   int                    answers_owed;

   int                    items_sent  = 0;     // every request transfer
   int                    pool_items  = 0;     // request transfers with a known action
   int                    rsp_seen    = 0;     // response transfers
   logic [STATUS_W-1:0]   last_status = ST_OK;
   logic                  calm        = 1'b0;  // no idling on either side while set
   int                    ready_hold  = 0;
   int                    quiet_cycles = 0;

   // action weights per style, in action-code order: acquire, release, partner, refill, drain
   int unsigned mix [3][5] = '{'{10, 40, 35, 10, 5},
                               '{30, 20, 20, 15, 15},
                               '{40, 10, 10, 15, 25}};

   // ring log settings forced on the first random phases: both out-of-range ends, then
   // the legal extremes
   logic [CFG_W-1:0] first_logs [4] = '{3'd7, 3'd0, 3'd3, 3'd6};

   shared_buffer_pool_rings_top i_dut (.*);

   shared_buffer_pool_rings_checker pool_check (.*);

   always #4 clock = ~clock;

   // response side: runs of ready and stalls, mostly short stalls with a few long ones
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_hold <= 0;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 99) < 60) begin
         rsp_tready <= 1'b1;
         ready_hold <= $urandom_range(0, 8);
      end else begin
         rsp_tready <= 1'b0;
         ready_hold <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                    : $urandom_range(3, 40);
      end
   end

   // count response transfers and keep the last status for the pool-empty check
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         rsp_seen    <= rsp_seen + 1;
         last_status <= rsp_tuser;
      end
   end

   // watchdog: a run of cycles with no transfer at all means the block hung
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [ADDR_W-1:0] rand_addr();
      return {$urandom, $urandom};
   endfunction

   // sender gap before a transfer, none while calm
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic [ACTION_W-1:0] pick_action(int style);
      int r;
      r = $urandom_range(0, 99);
      for (int a = 0; a < 5; a++) begin
         if (r < mix[style][a]) return ACTION_W'(a);
         r -= mix[style][a];
      end
      return ACT_DRAIN;
   endfunction

   // one request transfer; valid stays up when the next one follows with no gap
   task automatic send(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] addr);
      int gap;
      gap = idle_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= addr;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (act <= ACT_DRAIN) pool_items++;
   endtask

   // hold off the sender until every response has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (rsp_seen < items_sent) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // drain steps until one reports both rings empty
   task automatic empty_pool();
      do begin
         repeat (8) send(ACT_DRAIN, rand_addr());
         settle();
      end while (last_status != ST_DRAINED);
   endtask

   initial begin
      int phase;
      int len;
      int style;
      logic [CFG_W-1:0] log_val;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part, from the reset state: ring log 6, master off, rings empty

      send(ACT_ACQUIRE, '0);           // master check wins over an empty ring
      send(ACT_DRAIN, '1);             // both rings empty
      send(ACT_REFILL, rand_addr());   // nothing to move
      for (int a = ACT_FIRST_UNUSED; a <= ACT_LAST_UNUSED; a++)
         send(ACTION_W'(a), rand_addr());   // ignored actions give an all-zero response
      settle();
      write_reg(CSR_MASTER_EN, 3'd1);
      send(ACT_ACQUIRE, rand_addr());  // allocation ring empty

      // nine entries from counter zero: slots 0..8 under the full size
      send(ACT_RELEASE, '0);
      send(ACT_RELEASE, '1);
      send(ACT_RELEASE, 64'hAAAA_AAAA_AAAA_AAAA);
      send(ACT_RELEASE, 64'h5555_5555_5555_5555);
      send(ACT_RELEASE, 64'h8000_0000_0000_0001);
      repeat (4) send(ACT_RELEASE, rand_addr());

      // shrink to eight entries while nine are held: the ring now counts as full and
      // every slot read below was written at counter zero upward
      settle();
      write_reg(CSR_RING_LOG, 3'(MIN_RING_LOG));
      send(ACT_RELEASE, rand_addr());  // refused, ring over the new size
      send(ACT_PARTNER, '1);
      send(ACT_PARTNER, 64'h0123_4567_89AB_CDEF);
      settle();
      write_reg(CSR_MASTER_EN, 3'd0);
      send(ACT_ACQUIRE, rand_addr());  // not master, ring holds entries
      settle();
      write_reg(CSR_MASTER_EN, 3'd1);
      send(ACT_ACQUIRE, rand_addr());
      send(ACT_REFILL, rand_addr());   // allocation ring still full, moves nothing
      send(ACT_ACQUIRE, rand_addr());
      send(ACT_REFILL, rand_addr());   // room for exactly one
      send(ACT_DRAIN, rand_addr());    // return ring goes first
      settle();
      empty_pool();

      // --- random part: phases with their own settings; the ring log only changes
      // once the pool is empty so that no slot is read before it is written

      phase = 0;
      while (pool_items < ITEM_GOAL) begin
         settle();
         if (phase < 4 || $urandom_range(0, 99) < 30) begin
            empty_pool();
            log_val = (phase < 4) ? first_logs[phase] : CFG_W'($urandom_range(0, 7));
            write_reg(CSR_RING_LOG, log_val);
         end
         // upper write-data bits are don't-care for the master flag
         write_reg(CSR_MASTER_EN, {CFG_W'($urandom_range(0, 3)) << 1}
                                  | CFG_W'($urandom_range(0, 99) < 80));
         calm  <= ($urandom_range(0, 99) < 20);
         style = $urandom_range(FILL_UP, RUN_DOWN);
         len   = $urandom_range(20, 80);
         repeat (len) begin
            if ($urandom_range(0, 99) < 2)
               send(ACTION_W'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED)), rand_addr());
            else
               send(pick_action(style), rand_addr());
         end
         phase++;
      end

      // --- wind down: all responses in, then a quiet tail before the verdict
      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && answers_owed == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
